// ----- hdl/ppid_pkg.sv -----
// Shared types, widths and constants for the positional PID controller.
// Used by every module in hdl/; has no dependencies of its own.
`default_nettype none
package ppid_pkg;

  localparam int GainW  = 16;
  localparam int DrvW   = 16;
  localparam int SumW   = 32;
  localparam int ErrW   = 21;
  localparam int DerrW  = 22;
  localparam int KdW    = 24;
  localparam int MulAW  = 33;
  localparam int MulBW  = 25;
  localparam int ProdW  = MulAW + MulBW;
  localparam int PW     = 34;
  localparam int IW     = 41;
  localparam int DW     = 38;
  localparam int UW     = 40;
  localparam int CfgIdxW = 4;
  localparam int CfgDatW = 32;

  localparam logic signed [SumW-1:0] ACCUM_FLOOR_DEF = -32'sd5000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PROP_GAIN   = 4'd0,
    REG_INTEG_GAIN  = 4'd1,
    REG_DERIV_GAIN  = 4'd2,
    REG_DRIVE_UPPER = 4'd3,
    REG_DRIVE_LOWER = 4'd4,
    REG_INTEG_UPPER = 4'd5,
    REG_INTEG_LOWER = 4'd6,
    REG_ACCUM_UPPER = 4'd7
  } reg_idx_t;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_SUM  = 7'b0000010,
    ST_P    = 7'b0000100,
    ST_I    = 7'b0001000,
    ST_D    = 7'b0010000,
    ST_ANTI = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_t;

  typedef struct packed {
    logic [GainW-1:0] prop_gain;
    logic [GainW-1:0] integ_gain;
    logic [GainW-1:0] deriv_gain;
    logic [DrvW-1:0]  drive_upper;
    logic [DrvW-1:0]  drive_lower;
    logic [SumW-1:0]  integ_upper;
    logic [SumW-1:0]  integ_lower;
    logic [SumW-1:0]  accum_upper;
  } cfg_t;

  typedef struct packed {
    logic take;
    logic sum;
    logic p;
    logic i;
    logic d;
    logic anti;
    logic fin;
  } ctl_t;

endpackage
`default_nettype wire

// ----- hdl/ppid_cfg_regs.sv -----
// Configuration register file for the positional PID controller.
// Depends on ppid_pkg for register indexes and the cfg_t bundle.
`default_nettype none
module ppid_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [ppid_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [ppid_pkg::CfgDatW-1:0]  cfg_data,
  output ppid_pkg::cfg_t                     cfg
);

  ppid_pkg::cfg_t cfg_r;
  ppid_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        ppid_pkg::REG_PROP_GAIN:   cfg_nxt.prop_gain   = cfg_data[ppid_pkg::GainW-1:0];
        ppid_pkg::REG_INTEG_GAIN:  cfg_nxt.integ_gain  = cfg_data[ppid_pkg::GainW-1:0];
        ppid_pkg::REG_DERIV_GAIN:  cfg_nxt.deriv_gain  = cfg_data[ppid_pkg::GainW-1:0];
        ppid_pkg::REG_DRIVE_UPPER: cfg_nxt.drive_upper = cfg_data[ppid_pkg::DrvW-1:0];
        ppid_pkg::REG_DRIVE_LOWER: cfg_nxt.drive_lower = cfg_data[ppid_pkg::DrvW-1:0];
        ppid_pkg::REG_INTEG_UPPER: cfg_nxt.integ_upper = cfg_data[ppid_pkg::SumW-1:0];
        ppid_pkg::REG_INTEG_LOWER: cfg_nxt.integ_lower = cfg_data[ppid_pkg::SumW-1:0];
        ppid_pkg::REG_ACCUM_UPPER: cfg_nxt.accum_upper = cfg_data[ppid_pkg::SumW-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/ppid_mul.sv -----
// Shared signed multiplier with registered product.
// Depends on ppid_pkg for operand and product widths.
`default_nettype none
module ppid_mul (
  input  wire logic                              clk,
  input  wire logic signed [ppid_pkg::MulAW-1:0] a,
  input  wire logic signed [ppid_pkg::MulBW-1:0] b,
  output logic signed [ppid_pkg::ProdW-1:0]      prod
);

  logic signed [ppid_pkg::ProdW-1:0] prod_r;

  assign prod = prod_r;

  always_ff @(posedge clk) begin
    prod_r <= ppid_pkg::ProdW'(a) * ppid_pkg::ProdW'(b);
  end

endmodule
`default_nettype wire

// ----- hdl/ppid_ctrl.sv -----
// Sequencer for the positional PID controller: steps one sample through
// the shared multiplier. Depends on ppid_pkg for state_t and ctl_t.
`default_nettype none
module ppid_ctrl (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       out_free,
  output logic            in_ready,
  output ppid_pkg::ctl_t  ctl
);

  ppid_pkg::state_t state_r;
  ppid_pkg::state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ppid_pkg::ST_IDLE: if (in_valid) state_nxt = ppid_pkg::ST_SUM;
      ppid_pkg::ST_SUM:  state_nxt = ppid_pkg::ST_P;
      ppid_pkg::ST_P:    state_nxt = ppid_pkg::ST_I;
      ppid_pkg::ST_I:    state_nxt = ppid_pkg::ST_D;
      ppid_pkg::ST_D:    state_nxt = ppid_pkg::ST_ANTI;
      ppid_pkg::ST_ANTI: state_nxt = ppid_pkg::ST_OUT;
      ppid_pkg::ST_OUT:  if (out_free) state_nxt = ppid_pkg::ST_IDLE;
      default:           state_nxt = ppid_pkg::ST_IDLE;
    endcase
  end

  assign in_ready = (state_r == ppid_pkg::ST_IDLE);

  always_comb begin
    ctl.take = in_ready && in_valid;
    ctl.sum  = (state_r == ppid_pkg::ST_SUM);
    ctl.p    = (state_r == ppid_pkg::ST_P);
    ctl.i    = (state_r == ppid_pkg::ST_I);
    ctl.d    = (state_r == ppid_pkg::ST_D);
    ctl.anti = (state_r == ppid_pkg::ST_ANTI);
    ctl.fin  = (state_r == ppid_pkg::ST_OUT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ppid_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/positional_pid_controller.sv -----
// Positional PID controller with integral anti-windup, top level.
// Depends on ppid_pkg, ppid_cfg_regs, ppid_mul and ppid_ctrl.
//
// Each setpoint/measurement transfer yields one drive transfer. A sample's
// drive value lands in the output register in ST_OUT, after ST_SUM, ST_P,
// ST_I, ST_D and ST_ANTI; in_ready is low until the return to ST_IDLE. This
// sequence is set by the single 33x25 multiplier, which forms kp*td, kp*err,
// sum*ti and kd*(err-previous) one after another. A finished drive value
// waits in the output register while the next sample is taken in; the block
// holds only in its last step if that register is still occupied.
// cfg_ready is always high; write configuration while no sample is in flight.
`default_nettype none
module positional_pid_controller #(
  parameter logic signed [ppid_pkg::SumW-1:0] ACCUM_FLOOR = ppid_pkg::ACCUM_FLOOR_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [15:0]                  in_setpoint,
  input  wire logic signed [15:0]                  in_measured,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [ppid_pkg::DrvW-1:0]         out_drive,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [ppid_pkg::CfgIdxW-1:0]        cfg_index,
  input  wire logic [ppid_pkg::CfgDatW-1:0]        cfg_data
);

  localparam int ErrW  = ppid_pkg::ErrW;
  localparam int SumW  = ppid_pkg::SumW;
  localparam int DerrW = ppid_pkg::DerrW;
  localparam int KdW   = ppid_pkg::KdW;
  localparam int MulAW = ppid_pkg::MulAW;
  localparam int MulBW = ppid_pkg::MulBW;
  localparam int ProdW = ppid_pkg::ProdW;
  localparam int PW    = ppid_pkg::PW;
  localparam int IW    = ppid_pkg::IW;
  localparam int DW    = ppid_pkg::DW;
  localparam int UW    = ppid_pkg::UW;
  localparam int DrvW  = ppid_pkg::DrvW;

  ppid_pkg::cfg_t cfg;
  ppid_pkg::ctl_t ctl;
  logic           out_free;

  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [ProdW-1:0] prod;

  logic signed [ErrW-1:0]  err_r;
  logic signed [ErrW-1:0]  prev_r;
  logic signed [SumW-1:0]  error_sum_r;
  logic signed [SumW-1:0]  s_r;
  logic signed [DerrW-1:0] derr_r;
  logic        [KdW-1:0]   kd_r;
  logic signed [PW-1:0]    p_r;
  logic signed [IW-1:0]    i_raw_r;
  logic signed [SumW-1:0]  i_r;
  logic signed [DW-1:0]    d_r;
  logic                    out_valid_r;
  logic signed [DrvW-1:0]  out_drive_r;

  logic signed [16:0]      diff;
  logic signed [ErrW-1:0]  diff_x;
  logic signed [ErrW-1:0]  err_nxt;
  logic signed [SumW:0]    sum_raw;
  logic signed [SumW:0]    sum_hi;
  logic signed [SumW:0]    sum_cl;
  logic signed [ProdW-1:0] p10;
  logic signed [ProdW-1:0] p_sh;
  logic signed [ProdW-1:0] prod_sh;
  logic                    i_hi_hit;
  logic                    i_lo_hit;
  logic signed [IW-1:0]    i_hi;
  logic signed [IW-1:0]    i_fin;
  logic signed [SumW+1:0]  s_sub;
  logic signed [SumW+1:0]  s_dif;
  logic signed [SumW-1:0]  s_sat;
  logic signed [UW-1:0]    u_sum;
  logic signed [UW-1:0]    u_hi;
  logic signed [UW-1:0]    u_cl;

  ppid_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ppid_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .in_ready (in_ready),
    .ctl      (ctl)
  );

  ppid_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_drive = out_drive_r;

  // error times ten as shift-add
  always_comb begin
    diff    = 17'(in_setpoint) - 17'(in_measured);
    diff_x  = ErrW'(diff);
    err_nxt = (diff_x <<< 3) + (diff_x <<< 1);
  end

  // accumulate and clamp the error sum
  always_comb begin
    sum_raw = (SumW+1)'(error_sum_r) + (SumW+1)'(err_r);
    sum_hi  = (sum_raw > (SumW+1)'($signed(cfg.accum_upper)))
              ? (SumW+1)'($signed(cfg.accum_upper)) : sum_raw;
    sum_cl  = (sum_hi < (SumW+1)'(ACCUM_FLOOR)) ? (SumW+1)'(ACCUM_FLOOR) : sum_hi;
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (ctl.sum) begin
      mul_a = MulAW'($signed({1'b0, cfg.prop_gain}));
      mul_b = MulBW'($signed({1'b0, cfg.deriv_gain}));
    end else if (ctl.p) begin
      mul_a = MulAW'($signed({1'b0, cfg.prop_gain}));
      mul_b = MulBW'(err_r);
    end else if (ctl.i) begin
      mul_a = MulAW'(s_r);
      mul_b = MulBW'($signed({1'b0, cfg.integ_gain}));
    end else if (ctl.d) begin
      mul_a = MulAW'($signed({1'b0, kd_r}));
      mul_b = MulBW'(derr_r);
    end
  end

  always_comb begin
    p10     = (prod <<< 3) + (prod <<< 1);
    p_sh    = p10 >>> 8;
    prod_sh = prod >>> 8;
  end

  // integral clamp with anti-windup
  always_comb begin
    i_hi_hit = i_raw_r > IW'($signed(cfg.integ_upper));
    i_hi     = i_hi_hit ? IW'($signed(cfg.integ_upper)) : i_raw_r;
    i_lo_hit = i_hi < IW'($signed(cfg.integ_lower));
    i_fin    = i_lo_hit ? IW'($signed(cfg.integ_lower)) : i_hi;
    s_sub    = (i_hi_hit && i_lo_hit) ? ((SumW+2)'(err_r) <<< 1) : (SumW+2)'(err_r);
    s_dif    = (SumW+2)'(s_r) - s_sub;
    if (s_dif > (SumW+2)'($signed({1'b0, {(SumW-1){1'b1}}}))) begin
      s_sat = {1'b0, {(SumW-1){1'b1}}};
    end else if (s_dif < (SumW+2)'($signed({1'b1, {(SumW-1){1'b0}}}))) begin
      s_sat = {1'b1, {(SumW-1){1'b0}}};
    end else begin
      s_sat = s_dif[SumW-1:0];
    end
  end

  // sum of terms and drive clamp
  always_comb begin
    u_sum = UW'(p_r) + UW'(i_r) + UW'(d_r);
    u_hi  = (u_sum > UW'($signed(cfg.drive_upper))) ? UW'($signed(cfg.drive_upper)) : u_sum;
    u_cl  = (u_hi < UW'($signed(cfg.drive_lower))) ? UW'($signed(cfg.drive_lower)) : u_hi;
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      err_r <= err_nxt;
    end
    if (ctl.sum) begin
      s_r    <= sum_cl[SumW-1:0];
      derr_r <= DerrW'(err_r) - DerrW'(prev_r);
    end
    if (ctl.p) begin
      kd_r <= prod[KdW+7:8];
    end
    if (ctl.i) begin
      p_r <= p_sh[PW-1:0];
    end
    if (ctl.d) begin
      i_raw_r <= prod_sh[IW-1:0];
    end
    if (ctl.anti) begin
      d_r <= prod_sh[DW-1:0];
      i_r <= i_fin[SumW-1:0];
      if (i_hi_hit || i_lo_hit) begin
        s_r <= s_sat;
      end
    end
    if (ctl.fin) begin
      out_drive_r <= u_cl[DrvW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_sum_r <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.fin) begin
        error_sum_r <= s_r;
        prev_r      <= err_r;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- tb/ppid_checker.sv -----
// Channel monitor and drive predictor for the positional PID controller.
// Tracks register writes, predicts one drive value per sample transfer and
// compares drive transfers in order; depends on ppid_pkg only.
module ppid_checker import ppid_pkg::*; #(
  parameter logic signed [SumW-1:0] ACCUM_FLOOR = ACCUM_FLOOR_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  input  wire logic                    in_ready,
  input  wire logic signed [15:0]      in_setpoint,
  input  wire logic signed [15:0]      in_measured,
  input  wire logic                    out_valid,
  input  wire logic                    out_ready,
  input  wire logic signed [DrvW-1:0]  out_drive,
  input  wire logic                    cfg_valid,
  input  wire logic                    cfg_ready,
  input  wire logic [CfgIdxW-1:0]      cfg_index,
  input  wire logic [CfgDatW-1:0]      cfg_data,
  output int                           outstanding,
  output int                           fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint Int32Max = 64'sd2147483647;
  localparam longint Int32Min = -64'sd2147483648;
  localparam int     MaxPrinted = 100;

  longint prop_gain_q, integ_gain_q, deriv_gain_q;
  longint drive_hi, drive_lo, integ_hi, integ_lo, accum_hi;
  longint error_acc, last_err;
  logic signed [DrvW-1:0] drive_q[$];
  logic signed [DrvW-1:0] drive_want;
  int mismatches = 0;

  task automatic report_mismatch(input string msg);
    if (mismatches < MaxPrinted) $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  function automatic longint clip32(input longint v);
    if (v > Int32Max) return Int32Max;
    if (v < Int32Min) return Int32Min;
    return v;
  endfunction

  function automatic logic signed [DrvW-1:0] pid_drive(input longint sp, input longint ms);
    longint err, acc, p_term, i_term, d_term, kd, u;
    err = (sp - ms) * 10;
    acc = error_acc + err;
    if (acc > accum_hi) acc = accum_hi;
    if (acc < longint'(ACCUM_FLOOR)) acc = longint'(ACCUM_FLOOR);
    p_term = (10 * prop_gain_q * err) >>> 8;
    i_term = (acc * integ_gain_q) >>> 8;
    kd = (prop_gain_q * deriv_gain_q) >>> 8;
    d_term = (kd * (err - last_err)) >>> 8;
    if (i_term > integ_hi) begin
      acc = clip32(acc - err);
      i_term = integ_hi;
    end
    if (i_term < integ_lo) begin
      acc = clip32(acc - err);
      i_term = integ_lo;
    end
    u = p_term + i_term + d_term;
    if (u > drive_hi) u = drive_hi;
    if (u < drive_lo) u = drive_lo;
    error_acc = acc;
    last_err = err;
    return DrvW'(u);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_q = 0;
      integ_gain_q = 0;
      deriv_gain_q = 0;
      drive_hi = 0;
      drive_lo = 0;
      integ_hi = 0;
      integ_lo = 0;
      accum_hi = 0;
      error_acc = 0;
      last_err = 0;
      drive_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PROP_GAIN:   prop_gain_q = longint'(cfg_data[GainW-1:0]);
          REG_INTEG_GAIN:  integ_gain_q = longint'(cfg_data[GainW-1:0]);
          REG_DERIV_GAIN:  deriv_gain_q = longint'(cfg_data[GainW-1:0]);
          REG_DRIVE_UPPER: drive_hi = longint'($signed(cfg_data[DrvW-1:0]));
          REG_DRIVE_LOWER: drive_lo = longint'($signed(cfg_data[DrvW-1:0]));
          REG_INTEG_UPPER: integ_hi = longint'($signed(cfg_data[SumW-1:0]));
          REG_INTEG_LOWER: integ_lo = longint'($signed(cfg_data[SumW-1:0]));
          REG_ACCUM_UPPER: accum_hi = longint'($signed(cfg_data[SumW-1:0]));
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (drive_q.size() == 0) begin
          report_mismatch($sformatf("drive %0d with no sample pending", out_drive));
        end else begin
          drive_want = drive_q.pop_front();
          if (out_drive !== drive_want)
            report_mismatch($sformatf("drive %0d, want %0d", out_drive, drive_want));
        end
      end
      if (in_valid && in_ready)
        drive_q.push_back(pid_drive(longint'(in_setpoint), longint'(in_measured)));
    end
    outstanding <= drive_q.size();
    fail_count <= mismatches;
  end

endmodule

// ----- tb/positional_pid_controller_test.sv -----
// Top-level testbench for the positional PID controller: clock, reset,
// register settings, sample stimulus and the verdict.
// Depends on ppid_pkg, positional_pid_controller and ppid_checker.
module positional_pid_controller_test import ppid_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit     = 400000;
  localparam int HoldOffCycles  = 300;
  localparam int SegItems       = 68;
  localparam int WindupItems    = 40;
  localparam int TailCycles     = 20;
  localparam int FirstUnusedIdx = int'(REG_ACCUM_UPPER) + 1;
  localparam int LastIdx        = (1 << CfgIdxW) - 1;

  typedef struct {
    logic [GainW-1:0] kp, ti, td;
    logic [DrvW-1:0]  drv_hi, drv_lo;
    logic [SumW-1:0]  int_hi, int_lo, acc_hi;
  } pid_setting_t;

  logic clk;
  logic rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  logic signed [15:0] in_setpoint, in_measured;
  logic signed [DrvW-1:0] out_drive;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDatW-1:0] cfg_data;
  int outstanding, fail_count;
  int send_idle = 0;
  int recv_stall = 0;
  int hold_cycles = 0;
  int cycles = 0;
  logic signed [15:0] drift = '0;

  int send_pct[4] = '{0, 73, 0, 31};
  int recv_pct[4] = '{0, 0, 73, 31};

  positional_pid_controller i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_setpoint (in_setpoint),
    .in_measured (in_measured),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_drive   (out_drive),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  ppid_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_setpoint (in_setpoint),
    .in_measured (in_measured),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_drive   (out_drive),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] dat);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= dat;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_setting(input pid_setting_t st);
    logic [CfgDatW-1:0] pad;
    pad = $urandom();
    cfg_write(REG_PROP_GAIN, {pad[CfgDatW-1:GainW], st.kp});
    cfg_write(REG_INTEG_GAIN, {pad[CfgDatW-1:GainW], st.ti});
    cfg_write(REG_DERIV_GAIN, {pad[CfgDatW-1:GainW], st.td});
    if ($urandom_range(1))
      cfg_write(CfgIdxW'(FirstUnusedIdx + $urandom_range(LastIdx - FirstUnusedIdx)), $urandom());
    cfg_write(REG_DRIVE_UPPER, {pad[CfgDatW-1:DrvW], st.drv_hi});
    cfg_write(REG_DRIVE_LOWER, {pad[CfgDatW-1:DrvW], st.drv_lo});
    cfg_write(REG_INTEG_UPPER, st.int_hi);
    cfg_write(REG_INTEG_LOWER, st.int_lo);
    cfg_write(REG_ACCUM_UPPER, st.acc_hi);
    cfg_valid <= 1'b0;
  endtask

  // valid stays high into the next call unless an idle gap is drawn
  task automatic offer_sample(input logic signed [15:0] sp, input logic signed [15:0] ms);
    in_valid <= 1'b1;
    in_setpoint <= sp;
    in_measured <= ms;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do begin
        @(posedge clk);
      end while ($urandom_range(99) < send_idle);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic [GainW-1:0] rand_gain();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2, 3:    return GainW'($urandom_range(1023));
      default: return GainW'($urandom());
    endcase
  endfunction

  function automatic void pick_sample(output logic signed [15:0] sp,
                                      output logic signed [15:0] ms);
    int v;
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        sp = 16'($urandom());
        ms = 16'($urandom());
      end
      4, 5, 6, 7: begin
        v = int'(drift) + int'($urandom_range(64)) - 32;
        drift = 16'(v);
        ms = drift;
        sp = 16'(int'(drift) + int'($urandom_range(400)) - 200);
      end
      default: begin
        sp = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
        ms = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      end
    endcase
  endfunction

  initial begin
    pid_setting_t st;
    logic signed [15:0] sp, ms;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_setpoint <= '0;
    in_measured <= '0;
    out_ready <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_setting('{16'd256, 16'd64, 16'd128, 16'h7fff, 16'h8000,
                   32'd100000, -32'sd100000, 32'd1000000});
    offer_sample(0, 0);
    offer_sample(32767, -32768);
    offer_sample(-32768, 32767);
    offer_sample(32767, 32767);
    offer_sample(-32768, -32768);
    offer_sample(100, 0);
    offer_sample(100, 0);
    offer_sample(-100, 0);
    offer_sample(-100, 0);
    offer_sample(0, 0);
    wait_drained();

    load_setting('{16'hffff, 16'hffff, 16'hffff, 16'h7fff, 16'h8000,
                   32'd1000, -32'sd1000, 32'h7fffffff});
    repeat (3) offer_sample(32767, -32768);
    repeat (3) offer_sample(-32768, 32767);
    wait_drained();

    // crossed limits on the sum, the integral term and the drive
    load_setting('{16'd300, 16'd500, 16'd40, -16'sd100, 16'sd100,
                   -32'sd500, 32'sd500, 32'h80000000});
    offer_sample(1000, 0);
    offer_sample(-1000, 0);
    offer_sample(0, 0);
    offer_sample(50, -50);
    wait_drained();

    load_setting('{'0, '0, '0, '0, '0, '0, '0, '0});
    offer_sample(12345, -2345);
    offer_sample(0, 0);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      send_idle = send_pct[phase];
      recv_stall <= recv_pct[phase];
      for (int seg = 0; seg < 4; seg++) begin
        st.kp = rand_gain();
        st.ti = rand_gain();
        st.td = rand_gain();
        case ($urandom_range(9))
          0: begin
            st.drv_hi = 16'h7fff;
            st.drv_lo = 16'h8000;
          end
          1: begin
            st.drv_hi = 16'($urandom());
            st.drv_lo = 16'($urandom());
          end
          default: begin
            st.drv_hi = 16'($urandom_range(32767));
            st.drv_lo = 16'(-int'($urandom_range(32768)));
          end
        endcase
        case ($urandom_range(9))
          0: begin
            st.int_hi = 32'h7fffffff;
            st.int_lo = 32'h80000000;
          end
          1: begin
            st.int_hi = $urandom();
            st.int_lo = $urandom();
          end
          default: begin
            st.int_hi = 32'($urandom_range(20000000));
            st.int_lo = 32'(-int'($urandom_range(20000000)));
          end
        endcase
        case ($urandom_range(9))
          0:       st.acc_hi = 32'h7fffffff;
          1:       st.acc_hi = 32'h80000000;
          2:       st.acc_hi = $urandom();
          3:       st.acc_hi = 32'(-int'($urandom_range(10000)));
          default: st.acc_hi = 32'($urandom_range(50000000));
        endcase
        load_setting(st);
        if (phase == 0 && seg == 1) hold_cycles <= HoldOffCycles;
        for (int n = 0; n < SegItems; n++) begin
          pick_sample(sp, ms);
          offer_sample(sp, ms);
        end
        wait_drained();
      end
    end

    // repeated double clamping keeps growing the sum
    send_idle = 0;
    recv_stall <= 0;
    load_setting('{16'd1, 16'd0, 16'd0, 16'h7fff, 16'h8000,
                   32'hffffffff, 32'd1, 32'h7fffffff});
    for (int n = 0; n < WindupItems; n++)
      offer_sample(16'(-32768 + int'($urandom_range(768))),
                   16'(32000 + int'($urandom_range(767))));
    wait_drained();

    repeat (TailCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
